[hdl/gdc_pkg.sv]
`default_nettype none

package gdc_pkg;

    localparam int YEAR_W    = 12;
    localparam int WDAY_W    = 3;
    localparam int NYEARS_W  = 11;
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int COUNT_W   = 16;
    localparam int NUM_WDAYS = 7;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [YEAR_W-1:0]   RESET_START_YEAR    = 12'd1900;
    localparam logic [WDAY_W-1:0]   RESET_START_WEEKDAY = 3'd2;
    localparam logic [NYEARS_W-1:0] RESET_NUM_YEARS     = 11'd1;

    localparam logic [1:0] REG_START_YEAR    = 2'd0;
    localparam logic [1:0] REG_START_WEEKDAY = 2'd1;
    localparam logic [1:0] REG_NUM_YEARS     = 2'd2;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;
    localparam logic [WDAY_W-1:0]  WDAY_FRI  = 3'd6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [DAY_W-1:0]                    day;
        logic [MONTH_W-1:0]                  month;
        logic [YEAR_W-1:0]                   year;
        logic [WDAY_W-1:0]                   weekday;
        logic [NUM_WDAYS-1:0][COUNT_W-1:0]   counts;
    } cal_state_t;

    typedef struct packed {
        logic              reload;
        logic [YEAR_W-1:0] load_year;
        logic [WDAY_W-1:0] load_weekday;
        logic [YEAR_W-1:0] final_year;
    } cfg_t;

    // Gregorian leap test. The quotient by 100 is estimated as y*41/4096,
    // which is never low and at most one too high for 12-bit years, so a
    // single negative-remainder correction gives the exact quotient.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [17:0]        prod;
        logic [5:0]         q;
        logic [5:0]         q_fix;
        logic signed [13:0] r;
        logic               cent;
        prod  = {6'd0, y} * 18'd41;
        q     = prod[17:12];
        r     = $signed({2'b00, y}) - $signed({1'b0, 13'({7'd0, q} * 13'd100)});
        q_fix = (r < 14'sd0) ? (q - 6'd1) : q;
        cent  = (r == 14'sd0) || (r == -14'sd100);
        if (cent)
            return q_fix[1:0] == 2'd0;
        return y[1:0] == 2'd0;
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0] y);
        logic [DAY_W-1:0] d;
        case (m)
            4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
            MONTH_FEB:               d = is_leap(y) ? 5'd29 : 5'd28;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[hdl/gdc_cfg.sv]
`default_nettype none

module gdc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gdc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [gdc_pkg::DATA_W-1:0]    pwdata,
    output logic      [gdc_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output gdc_pkg::cfg_t                      cfg
);

    logic [gdc_pkg::YEAR_W-1:0]   start_year_reg;
    logic [gdc_pkg::WDAY_W-1:0]   start_weekday_reg;
    logic [gdc_pkg::NYEARS_W-1:0] num_years_reg;

    logic [1:0] idx;
    logic       wr;
    logic       wr_year;
    logic       wr_wday;
    logic       wr_nyears;
    logic [gdc_pkg::WDAY_W-1:0] wday_src;

    assign idx       = paddr[3:2];
    assign pready    = 1'b1;
    assign wr        = psel && penable && pwrite;
    assign wr_year   = wr && (idx == gdc_pkg::REG_START_YEAR);
    assign wr_wday   = wr && (idx == gdc_pkg::REG_START_WEEKDAY);
    assign wr_nyears = wr && (idx == gdc_pkg::REG_NUM_YEARS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_year_reg    <= gdc_pkg::RESET_START_YEAR;
            start_weekday_reg <= gdc_pkg::RESET_START_WEEKDAY;
            num_years_reg     <= gdc_pkg::RESET_NUM_YEARS;
        end
        else
        begin
            if (wr_year)
                start_year_reg <= pwdata[gdc_pkg::YEAR_W-1:0];
            if (wr_wday)
                start_weekday_reg <= pwdata[gdc_pkg::WDAY_W-1:0];
            if (wr_nyears)
                num_years_reg <= pwdata[gdc_pkg::NYEARS_W-1:0];
        end
    end

    // The reload takes the value being written in the same transfer.
    always_comb
    begin
        wday_src          = wr_wday ? pwdata[gdc_pkg::WDAY_W-1:0] : start_weekday_reg;
        cfg.reload        = wr_year || wr_wday || wr_nyears;
        cfg.load_year     = wr_year ? pwdata[gdc_pkg::YEAR_W-1:0] : start_year_reg;
        cfg.load_weekday  = (wday_src > gdc_pkg::WDAY_FRI) ? '0 : wday_src;
        cfg.final_year    = start_year_reg + {1'b0, num_years_reg} - 12'd1;
    end

    always_comb
    begin
        case (idx)
            gdc_pkg::REG_START_YEAR:
                prdata = {{(gdc_pkg::DATA_W-gdc_pkg::YEAR_W){1'b0}}, start_year_reg};
            gdc_pkg::REG_START_WEEKDAY:
                prdata = {{(gdc_pkg::DATA_W-gdc_pkg::WDAY_W){1'b0}}, start_weekday_reg};
            gdc_pkg::REG_NUM_YEARS:
                prdata = {{(gdc_pkg::DATA_W-gdc_pkg::NYEARS_W){1'b0}}, num_years_reg};
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/gdc_step.sv]
`default_nettype none

module gdc_step (
    input  wire gdc_pkg::cal_state_t         cur,
    input  wire logic                        tick,
    input  wire logic [gdc_pkg::YEAR_W-1:0]  final_year,
    output gdc_pkg::cal_state_t              nxt,
    output logic                             period_end
);

    logic [gdc_pkg::DAY_W-1:0] dim;

    assign dim = gdc_pkg::days_in(cur.month, cur.year);

    always_comb
    begin
        nxt = cur;
        if (tick)
        begin
            // The 13th is tallied against the weekday it falls on, before the step.
            for (int i = 0; i < gdc_pkg::NUM_WDAYS; i++)
            begin
                if (cur.day == 5'd13 && cur.weekday == 3'(i)
                    && cur.counts[i] != gdc_pkg::COUNT_MAX)
                    nxt.counts[i] = cur.counts[i] + 16'd1;
            end
            if (cur.day >= dim)
            begin
                nxt.day = 5'd1;
                if (cur.month >= gdc_pkg::MONTH_DEC)
                begin
                    nxt.month = gdc_pkg::MONTH_JAN;
                    nxt.year  = cur.year + 12'd1;
                end
                else
                    nxt.month = cur.month + 4'd1;
            end
            else
                nxt.day = cur.day + 5'd1;
            nxt.weekday = (cur.weekday >= gdc_pkg::WDAY_FRI) ? '0 : cur.weekday + 3'd1;
        end
        period_end = (nxt.day == 5'd31) && (nxt.month == gdc_pkg::MONTH_DEC)
                     && (nxt.year == final_year);
    end

endmodule

`default_nettype wire

[hdl/gregorian_day_counter_thirteenths.sv]
// Channel   Handshake               Payload
// input     in_valid / in_ready     day_tick
// result    out_valid / out_ready   date, weekday, seven 13th counts, period_end
// config    APB psel/penable        start_year, start_weekday, num_years
//
// Each accepted transfer shows its registered result in the cycle after; one
// transfer per cycle is sustained while out_ready is high, via the single date-step stage.
// in_ready stays high while the result register is empty or being drained.
// Reset restores the 1900-01-01 Monday start with cleared counters.
// A configuration write reloads the calendar at the edge of the access cycle.
`default_nettype none

module gregorian_day_counter_thirteenths (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          day_tick,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gdc_pkg::DAY_W-1:0]          day_of_month,
    output logic [gdc_pkg::MONTH_W-1:0]        month_number,
    output logic [gdc_pkg::YEAR_W-1:0]         year_value,
    output logic [gdc_pkg::WDAY_W-1:0]         weekday_now,
    output logic [gdc_pkg::COUNT_W-1:0]        count_sat,
    output logic [gdc_pkg::COUNT_W-1:0]        count_sun,
    output logic [gdc_pkg::COUNT_W-1:0]        count_mon,
    output logic [gdc_pkg::COUNT_W-1:0]        count_tue,
    output logic [gdc_pkg::COUNT_W-1:0]        count_wed,
    output logic [gdc_pkg::COUNT_W-1:0]        count_thu,
    output logic [gdc_pkg::COUNT_W-1:0]        count_fri,
    output logic                               period_end,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gdc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [gdc_pkg::DATA_W-1:0]    pwdata,
    output logic      [gdc_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    gdc_pkg::cfg_t       cfg;
    gdc_pkg::cal_state_t state_reg;
    gdc_pkg::cal_state_t state_next;
    gdc_pkg::cal_state_t res_reg;
    logic                end_reg;
    logic                end_next;
    logic                out_valid_reg;
    logic                accept;

    gdc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gdc_step u_step (
        .cur        (state_reg),
        .tick       (day_tick),
        .final_year (cfg.final_year),
        .nxt        (state_next),
        .period_end (end_next)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.day     <= 5'd1;
            state_reg.month   <= gdc_pkg::MONTH_JAN;
            state_reg.year    <= gdc_pkg::RESET_START_YEAR;
            state_reg.weekday <= gdc_pkg::RESET_START_WEEKDAY;
            state_reg.counts  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.reload)
            begin
                state_reg.day     <= 5'd1;
                state_reg.month   <= gdc_pkg::MONTH_JAN;
                state_reg.year    <= cfg.load_year;
                state_reg.weekday <= cfg.load_weekday;
                state_reg.counts  <= '0;
            end
            else if (accept)
                state_reg <= state_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= state_next;
            end_reg <= end_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign day_of_month = res_reg.day;
    assign month_number = res_reg.month;
    assign year_value   = res_reg.year;
    assign weekday_now  = res_reg.weekday;
    assign count_sat    = res_reg.counts[0];
    assign count_sun    = res_reg.counts[1];
    assign count_mon    = res_reg.counts[2];
    assign count_tue    = res_reg.counts[3];
    assign count_wed    = res_reg.counts[4];
    assign count_thu    = res_reg.counts[5];
    assign count_fri    = res_reg.counts[6];
    assign period_end   = end_reg;

endmodule

`default_nettype wire

[hdl/gdc_checker.sv]
`default_nettype none

module gdc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [4:0]  day_of_month,
    input wire logic [3:0]  month_number,
    input wire logic [11:0] year_value,
    input wire logic        period_end
);

    // An empty result register never holds back the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // Every accepted input transfer shows a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted input produced no result");

    // The period end flag only marks December 31.
    a_end_is_dec31: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && period_end) |-> (day_of_month == 5'd31 && month_number == 4'd11))
        else $error("period_end on a date other than December 31");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(day_of_month)
                                       && $stable(year_value)))
        else $error("stalled result changed");

endmodule

bind gregorian_day_counter_thirteenths gdc_checker u_gdc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .day_of_month (day_of_month),
    .month_number (month_number),
    .year_value   (year_value),
    .period_end   (period_end)
);

`default_nettype wire
